### rtl/dnsp_pkg.sv
// dnsp_pkg: shared types and constants for the dns message section parser
// no dependencies

package dnsp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QLEN   = 4'd1,
        PH_QTEXT  = 4'd2,
        PH_QTYPE  = 4'd3,
        PH_QCLASS = 4'd4,
        PH_ALEN   = 4'd5,
        PH_ATEXT  = 4'd6,
        PH_ATYPE  = 4'd7,
        PH_ACLASS = 4'd8,
        PH_TTL    = 4'd9,
        PH_RDLEN  = 4'd10,
        PH_RDATA  = 4'd11,
        PH_TRAIL  = 4'd12
    } phase_t;

    localparam logic [3:0] CLS_HEADER  = 4'd0;
    localparam logic [3:0] CLS_LABLEN  = 4'd1;
    localparam logic [3:0] CLS_LABTEXT = 4'd2;
    localparam logic [3:0] CLS_NAMEEND = 4'd3;
    localparam logic [3:0] CLS_TYPE    = 4'd4;
    localparam logic [3:0] CLS_CLASS   = 4'd5;
    localparam logic [3:0] CLS_TTL     = 4'd6;
    localparam logic [3:0] CLS_RDLEN   = 4'd7;
    localparam logic [3:0] CLS_RDATA   = 4'd8;
    localparam logic [3:0] CLS_TRAIL   = 4'd9;

    localparam logic [1:0] SEC_NONE = 2'd0;
    localparam logic [1:0] SEC_QUES = 2'd1;
    localparam logic [1:0] SEC_ANS  = 2'd2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] NUL_CHAR = 8'h00;
    localparam logic [3:0] HEADER_LAST = 4'd11;

    localparam int QUEUE_DEPTH = 2;

    // classified byte carried from front to back
    typedef struct packed {
        logic [3:0]  byte_class;
        logic [1:0]  section;
        logic [15:0] record_index;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic [31:0] field_value;
        logic        field_done;
        logic        message_done;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### rtl/dns_message_section_parser_core.sv
// dns message section parser: one message byte in, one classified result out
// path: an input transfer is written into the queue, then into the output register
// throughput: one byte per cycle while the queue is not full
// reset: aresetn synchronous active low clears parse state, queue and mode
// depends on dnsp_pkg, dnsp_front, dnsp_queue, dnsp_back

module dns_message_section_parser_core #(
    parameter int QUEUE_DEPTH = dnsp_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // network_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // data_byte
    input  logic        s_tuser,         // message_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_class[3:0] section[5:4] record_index[21:6] out_byte[29:22]
    // out_valid[30] field_value[62:31] field_done[63] message_done[64], zero fill
    output logic [71:0] m_tdata
);

    logic              mode_reg;
    logic              in_fire, q_full, q_empty, q_rd;
    dnsp_pkg::result_t front_res, q_data, out_res;

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) mode_reg <= 1'b0;
        else if (cfg_wr_en) mode_reg <= cfg_wr_data;
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    dnsp_front u_front (
        .aclk, .aresetn, .network_mode(mode_reg), .in_fire,
        .data_byte(s_tdata), .message_start(s_tuser), .result(front_res)
    );

    dnsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .wr_en(in_fire), .wr_data(front_res), .full(q_full),
        .rd_en(q_rd), .rd_data(q_data), .empty(q_empty)
    );

    dnsp_back u_back (
        .aclk, .aresetn, .q_empty, .q_data, .q_rd,
        .m_tvalid, .m_tready, .m_data(out_res)
    );

    // pack result fields, first field lowest
    assign m_tdata = {7'd0, out_res.message_done, out_res.field_done,
                      out_res.field_value, out_res.out_valid, out_res.out_byte,
                      out_res.record_index, out_res.section, out_res.byte_class};

    // no transfer into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !in_fire) else $error("queue overflow");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // field value only with field_done
    a_field_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[63] |-> m_tdata[62:31] == 32'd0)
        else $error("field value without field_done");

endmodule

### rtl/dnsp_front.sv
// dnsp_front: per-byte parse state machine and classifier
// depends on dnsp_pkg

module dnsp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  network_mode,
    input  logic                  in_fire,
    input  logic [7:0]            data_byte,
    input  logic                  message_start,
    output dnsp_pkg::result_t     result
);

    dnsp_pkg::phase_t phase_reg, phase_next, ph;
    logic [3:0]  bif_reg, bif_next, bif;
    logic [7:0]  lrem_reg, lrem_next, lrem;
    logic        lseen_reg, lseen_next, lseen;
    logic [15:0] qleft_reg, qleft_next, qleft;
    logic [15:0] aleft_reg, aleft_next, aleft;
    logic [15:0] rleft_reg, rleft_next, rleft;
    logic [31:0] acc_reg, acc_next, acc;
    logic [15:0] rec_reg, rec_next, rec;
    logic [31:0] acc_new;
    logic        fld_last;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= dnsp_pkg::PH_HEADER;
            bif_reg   <= '0;
            lrem_reg  <= '0;
            lseen_reg <= 1'b0;
            qleft_reg <= '0;
            aleft_reg <= '0;
            rleft_reg <= '0;
            acc_reg   <= '0;
            rec_reg   <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            lrem_reg  <= lrem_next;
            lseen_reg <= lseen_next;
            qleft_reg <= qleft_next;
            aleft_reg <= aleft_next;
            rleft_reg <= rleft_next;
            acc_reg   <= acc_next;
            rec_reg   <= rec_next;
        end
    end

    // field value in the reporting byte order
    function automatic logic [31:0] report(input logic [31:0] v, input logic four,
                                           input logic net);
        logic [31:0] r;
        begin
            if (four) r = net ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
            else      r = net ? {16'd0, v[7:0], v[15:8]} : {16'd0, v[15:0]};
            return r;
        end
    endfunction

    // next state and classification
    always_comb begin
        ph    = message_start ? dnsp_pkg::PH_HEADER : phase_reg;
        bif   = message_start ? 4'd0  : bif_reg;
        lrem  = message_start ? 8'd0  : lrem_reg;
        lseen = message_start ? 1'b0  : lseen_reg;
        qleft = message_start ? 16'd0 : qleft_reg;
        aleft = message_start ? 16'd0 : aleft_reg;
        rleft = message_start ? 16'd0 : rleft_reg;
        acc   = message_start ? 32'd0 : acc_reg;
        rec   = message_start ? 16'd0 : rec_reg;

        phase_next = ph;   bif_next = bif;     lrem_next = lrem;
        lseen_next = lseen; qleft_next = qleft; aleft_next = aleft;
        rleft_next = rleft; acc_next = acc;     rec_next = rec;

        acc_new  = (bif == 4'd0) ? {24'd0, data_byte} : {acc[23:0], data_byte};
        fld_last = 1'b0;

        result = '0;
        result.record_index = rec;

        case (ph)
            dnsp_pkg::PH_HEADER: begin
                result.byte_class   = dnsp_pkg::CLS_HEADER;
                result.record_index = '0;
                acc_next = bif[0] ? {acc[23:0], data_byte} : {24'd0, data_byte};
                bif_next = bif + 4'd1;
                if (bif[0]) begin
                    result.field_done  = 1'b1;
                    result.field_value = report(acc_next, 1'b0, network_mode);
                    if (bif == 4'd5) qleft_next = acc_next[15:0];
                    if (bif == 4'd7) aleft_next = acc_next[15:0];
                end
                if (bif >= dnsp_pkg::HEADER_LAST) begin
                    bif_next   = '0;
                    rec_next   = '0;
                    lseen_next = 1'b0;
                    if (qleft_next != 16'd0) phase_next = dnsp_pkg::PH_QLEN;
                    else if (aleft_next != 16'd0) phase_next = dnsp_pkg::PH_ALEN;
                    else begin
                        phase_next = dnsp_pkg::PH_TRAIL;
                        result.message_done = 1'b1;
                    end
                end
            end
            dnsp_pkg::PH_QLEN, dnsp_pkg::PH_ALEN: begin
                result.section   = (ph == dnsp_pkg::PH_QLEN) ? dnsp_pkg::SEC_QUES
                                                            : dnsp_pkg::SEC_ANS;
                result.out_valid = 1'b1;
                if (data_byte == 8'd0) begin
                    result.byte_class = dnsp_pkg::CLS_NAMEEND;
                    result.out_byte   = dnsp_pkg::NUL_CHAR;
                    bif_next = '0;
                    phase_next = (ph == dnsp_pkg::PH_QLEN) ? dnsp_pkg::PH_QTYPE
                                                          : dnsp_pkg::PH_ATYPE;
                end else begin
                    result.byte_class = dnsp_pkg::CLS_LABLEN;
                    if (network_mode) result.out_byte = data_byte;
                    else if (lseen)  result.out_byte = dnsp_pkg::DOT_CHAR;
                    else             result.out_valid = 1'b0;
                    lseen_next = 1'b1;
                    lrem_next  = data_byte;
                    phase_next = (ph == dnsp_pkg::PH_QLEN) ? dnsp_pkg::PH_QTEXT
                                                          : dnsp_pkg::PH_ATEXT;
                end
            end
            dnsp_pkg::PH_QTEXT, dnsp_pkg::PH_ATEXT: begin
                result.section    = (ph == dnsp_pkg::PH_QTEXT) ? dnsp_pkg::SEC_QUES
                                                              : dnsp_pkg::SEC_ANS;
                result.byte_class = dnsp_pkg::CLS_LABTEXT;
                result.out_byte   = data_byte;
                result.out_valid  = 1'b1;
                lrem_next = lrem - 8'd1;
                if (lrem_next == 8'd0)
                    phase_next = (ph == dnsp_pkg::PH_QTEXT) ? dnsp_pkg::PH_QLEN
                                                           : dnsp_pkg::PH_ALEN;
            end
            dnsp_pkg::PH_QTYPE, dnsp_pkg::PH_ATYPE, dnsp_pkg::PH_QCLASS,
            dnsp_pkg::PH_ACLASS, dnsp_pkg::PH_TTL, dnsp_pkg::PH_RDLEN: begin
                acc_next = acc_new;
                bif_next = bif + 4'd1;
                fld_last = (ph == dnsp_pkg::PH_TTL) ? (bif_next >= 4'd4)
                                                    : (bif_next >= 4'd2);
                result.section = (ph == dnsp_pkg::PH_QTYPE || ph == dnsp_pkg::PH_QCLASS)
                                 ? dnsp_pkg::SEC_QUES : dnsp_pkg::SEC_ANS;
                case (ph)
                    dnsp_pkg::PH_QTYPE, dnsp_pkg::PH_ATYPE:
                        result.byte_class = dnsp_pkg::CLS_TYPE;
                    dnsp_pkg::PH_TTL:   result.byte_class = dnsp_pkg::CLS_TTL;
                    dnsp_pkg::PH_RDLEN: result.byte_class = dnsp_pkg::CLS_RDLEN;
                    default:            result.byte_class = dnsp_pkg::CLS_CLASS;
                endcase
                if (fld_last) begin
                    bif_next = '0;
                    result.field_done  = 1'b1;
                    result.field_value = report(acc_new, ph == dnsp_pkg::PH_TTL,
                                                network_mode);
                    case (ph)
                        dnsp_pkg::PH_QTYPE:  phase_next = dnsp_pkg::PH_QCLASS;
                        dnsp_pkg::PH_ATYPE:  phase_next = dnsp_pkg::PH_ACLASS;
                        dnsp_pkg::PH_ACLASS: phase_next = dnsp_pkg::PH_TTL;
                        dnsp_pkg::PH_TTL:    phase_next = dnsp_pkg::PH_RDLEN;
                        dnsp_pkg::PH_QCLASS: begin
                            qleft_next = qleft - 16'd1;
                            rec_next   = rec + 16'd1;
                            lseen_next = 1'b0;
                            if (qleft_next != 16'd0) phase_next = dnsp_pkg::PH_QLEN;
                            else begin
                                rec_next = '0;
                                if (aleft != 16'd0) phase_next = dnsp_pkg::PH_ALEN;
                                else begin
                                    phase_next = dnsp_pkg::PH_TRAIL;
                                    result.message_done = 1'b1;
                                end
                            end
                        end
                        default: begin
                            rleft_next = acc_new[15:0];
                            if (acc_new[15:0] != 16'd0) phase_next = dnsp_pkg::PH_RDATA;
                            else begin
                                aleft_next = aleft - 16'd1;
                                rec_next   = rec + 16'd1;
                                lseen_next = 1'b0;
                                if (aleft_next != 16'd0) phase_next = dnsp_pkg::PH_ALEN;
                                else begin
                                    phase_next = dnsp_pkg::PH_TRAIL;
                                    rec_next   = '0;
                                    result.message_done = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            dnsp_pkg::PH_RDATA: begin
                result.section    = dnsp_pkg::SEC_ANS;
                result.byte_class = dnsp_pkg::CLS_RDATA;
                result.out_byte   = data_byte;
                result.out_valid  = 1'b1;
                rleft_next = rleft - 16'd1;
                if (rleft_next == 16'd0) begin
                    aleft_next = aleft - 16'd1;
                    rec_next   = rec + 16'd1;
                    lseen_next = 1'b0;
                    if (aleft_next != 16'd0) phase_next = dnsp_pkg::PH_ALEN;
                    else begin
                        phase_next = dnsp_pkg::PH_TRAIL;
                        rec_next   = '0;
                        result.message_done = 1'b1;
                    end
                end
            end
            default: begin
                result.byte_class   = dnsp_pkg::CLS_TRAIL;
                result.record_index = '0;
                phase_next = dnsp_pkg::PH_TRAIL;
            end
        endcase
    end

endmodule

### rtl/dnsp_queue.sv
// dnsp_queue: short fifo of classified results between front and back
// depends on dnsp_pkg

module dnsp_queue #(
    parameter int DEPTH = dnsp_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  dnsp_pkg::result_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output dnsp_pkg::result_t rd_data,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dnsp_pkg::result_t mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rptr_reg];

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (wr_en)
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + AW'(1);
            if (rd_en)
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

### rtl/dnsp_back.sv
// dnsp_back: output register stage driving the result stream
// depends on dnsp_pkg

module dnsp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  dnsp_pkg::result_t q_data,
    output logic              q_rd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dnsp_pkg::result_t m_data
);

    logic              valid_reg;
    dnsp_pkg::result_t data_reg;

    // load when the output slot is free or being drained
    assign q_rd     = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (q_rd) valid_reg <= 1'b1;
        else if (m_tready) valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (q_rd) data_reg <= q_data;
    end

endmodule
